// File: design/assert_macros.svh
// Assertion macros shared by the voice allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mva_pkg.sv
// Shared types and constants for the MIDI voice allocator.
package mva_pkg;

  localparam int VOICES_DEF  = 4;
  localparam int MAX_RESULTS = 4;

  localparam int KIND_W   = 2;
  localparam int CHAN_W   = 4;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int VOICE_W  = 2;
  localparam int LEVEL_W  = 5;
  localparam int RCNT_W   = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_ON  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF = 2'd1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STOP  = 1'b1;

  typedef struct packed {
    logic load;
    logic emit_steal;
    logic emit_start;
    logic emit_mono;
    logic scan_step;
  } mva_cmd_t;

  typedef struct packed {
    logic poly;
    logic served;
    logic on;
    logic off;
    logic full;
    logic slot_free;
    logic scan_stall;
    logic scan_end;
  } mva_sts_t;

endpackage

// File: design/mva_ctrl.sv
// Controller state machine sequencing decode, start, steal, mono and release scan.
`include "assert_macros.svh"

module mva_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  mva_pkg::mva_sts_t sts,
  output mva_pkg::mva_cmd_t cmd
);
  import mva_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_STEAL,
    S_START,
    S_MONO,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.served || !(sts.on || sts.off)) begin
          state_nxt = S_IDLE;
        end else if (!sts.poly) begin
          state_nxt = S_MONO;
        end else if (sts.on) begin
          state_nxt = sts.full ? S_STEAL : S_START;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_STEAL: begin
        if (sts.slot_free) begin
          cmd.emit_steal = 1'b1;
          state_nxt      = S_START;
        end
      end
      S_START: begin
        if (sts.slot_free) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_MONO: begin
        if (sts.slot_free) begin
          cmd.emit_mono = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!sts.scan_stall) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_IMP(a_emit_needs_slot, cmd.emit_steal || cmd.emit_start || cmd.emit_mono,
    sts.slot_free, "result issued while output register is occupied")
  `ASSERT_NXT(a_steal_then_start, cmd.emit_steal, state_r == S_START,
    "steal stop not followed by restart")

endmodule

// File: design/mva_dpath.sv
// Datapath: voice ring, held notes, busy count, input capture and output register.
`include "assert_macros.svh"

module mva_dpath #(
  parameter int VOICES = mva_pkg::VOICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mva_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [mva_pkg::KIND_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mva_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,
  input  mva_pkg::mva_cmd_t               cmd,
  output mva_pkg::mva_sts_t               sts
);
  import mva_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int BW = $clog2(VOICES + 1);
  localparam logic [VW-1:0]     LAST_IDX  = VW'(VOICES - 1);
  localparam logic [BW-1:0]     BUSY_MAX  = BW'(VOICES);
  localparam logic [CHAN_W:0]   CHAN_LIM  = (CHAN_W + 1)'(VOICES);
  localparam logic [RCNT_W-1:0] RCNT_MAX  = RCNT_W'(MAX_RESULTS);
  localparam logic [RCNT_W-1:0] RCNT_FIN  = RCNT_W'(MAX_RESULTS - 1);

  logic                  poly_r;
  logic [VW-1:0]         free_ring_r [VOICES];
  logic [VW-1:0]         head_r, tail_r;
  logic [BW-1:0]         busy_r;
  logic [NOTE_W-1:0]     held_note_r [VOICES];
  logic [VOICES-1:0]     held_valid_r;
  logic [KIND_W-1:0]     kind_r;
  logic [CHAN_W-1:0]     chan_r;
  logic [NOTE_W-1:0]     note_r;
  logic [VEL_W-1:0]      vel_r;
  logic [VW-1:0]         idx_r;
  logic [RCNT_W-1:0]     rcnt_r;
  logic                  out_valid_r;
  logic [VOICE_W-1:0]    voice_r;
  logic                  action_r;
  logic [NOTE_W-1:0]     pitch_r;
  logic [LEVEL_W-1:0]    level_r;
  logic                  lvalid_r;
  logic                  last_r;

  logic [VOICES-1:0]     match_vec;
  logic                  later_match;
  logic                  cur_match;
  logic                  cnt_ok;
  logic                  scan_emit;
  logic                  emit_any;
  logic                  slot_free;
  logic                  on, off;
  logic [VW-1:0]         ring_v;
  logic [VW-1:0]         head_next, tail_next;

  assign cfg_ready = 1'b1;

  assign on  = (kind_r == KIND_ON) && (vel_r != '0);
  assign off = (kind_r == KIND_OFF) || ((kind_r == KIND_ON) && (vel_r == '0));

  assign ring_v    = free_ring_r[head_r];
  assign head_next = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_next = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;

  always_comb begin
    later_match = 1'b0;
    for (int j = 0; j < VOICES; j++) begin
      match_vec[j] = held_valid_r[j] && (held_note_r[j] == note_r);
      if (match_vec[j] && (j > int'(idx_r))) begin
        later_match = 1'b1;
      end
    end
  end

  assign cur_match = match_vec[idx_r];
  assign cnt_ok    = (rcnt_r < RCNT_MAX);
  assign slot_free = !out_valid_r || out_tready;
  assign scan_emit = cmd.scan_step && cur_match && cnt_ok;
  assign emit_any  = cmd.emit_steal || cmd.emit_start || cmd.emit_mono || scan_emit;

  always_comb begin
    sts            = '0;
    sts.poly       = poly_r;
    sts.served     = poly_r ? (chan_r == '0) : ({1'b0, chan_r} < CHAN_LIM);
    sts.on         = on;
    sts.off        = off;
    sts.full       = (busy_r >= BUSY_MAX);
    sts.slot_free  = slot_free;
    sts.scan_stall = cur_match && cnt_ok && !slot_free;
    sts.scan_end   = (idx_r == LAST_IDX);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r       <= 1'b1;
      head_r       <= '0;
      tail_r       <= '0;
      busy_r       <= '0;
      held_valid_r <= '0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      rcnt_r       <= '0;
      for (int i = 0; i < VOICES; i++) begin
        free_ring_r[i] <= VW'(i);
      end
    end else begin
      if (cfg_valid) begin
        poly_r <= cfg_data;
      end
      if (cmd.load) begin
        idx_r  <= '0;
        rcnt_r <= '0;
      end
      if (emit_any) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit_start) begin
        held_valid_r[ring_v] <= 1'b1;
        if (busy_r < BUSY_MAX) begin
          head_r <= head_next;
          busy_r <= busy_r + 1'b1;
        end
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (cur_match) begin
          held_valid_r[idx_r] <= 1'b0;
          free_ring_r[tail_r] <= idx_r;
          tail_r              <= tail_next;
          if (busy_r != '0) begin
            busy_r <= busy_r - 1'b1;
          end
          if (cnt_ok) begin
            rcnt_r <= rcnt_r + 1'b1;
          end
        end
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_tuser;
      chan_r <= in_tdata[CHAN_W-1:0];
      note_r <= in_tdata[CHAN_W +: NOTE_W];
      vel_r  <= in_tdata[CHAN_W+NOTE_W +: VEL_W];
    end
    if (cmd.emit_start) begin
      held_note_r[ring_v] <= note_r;
    end
    if (cmd.emit_steal) begin
      voice_r  <= VOICE_W'(ring_v);
      action_r <= ACT_STOP;
      pitch_r  <= '0;
      level_r  <= '0;
      lvalid_r <= 1'b0;
      last_r   <= 1'b0;
    end
    if (cmd.emit_start) begin
      voice_r  <= VOICE_W'(ring_v);
      action_r <= ACT_START;
      pitch_r  <= note_r;
      level_r  <= vel_r[VEL_W-1:2];
      lvalid_r <= 1'b1;
      last_r   <= 1'b1;
    end
    if (cmd.emit_mono) begin
      voice_r  <= VOICE_W'(chan_r);
      action_r <= on ? ACT_START : ACT_STOP;
      pitch_r  <= on ? note_r : '0;
      level_r  <= '0;
      lvalid_r <= 1'b0;
      last_r   <= 1'b1;
    end
    if (scan_emit) begin
      voice_r  <= VOICE_W'(idx_r);
      action_r <= ACT_STOP;
      pitch_r  <= '0;
      level_r  <= '0;
      lvalid_r <= 1'b0;
      last_r   <= (rcnt_r == RCNT_FIN) || !later_match;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, lvalid_r, level_r, pitch_r, voice_r};
  assign out_tuser  = action_r;
  assign out_tlast  = last_r;

  `ASSERT_IMP(a_busy_range, 1'b1, busy_r <= BUSY_MAX, "busy count exceeds voice count")
  `ASSERT_IMP(a_busy_matches_held, 1'b1, $countones(held_valid_r) == int'(busy_r),
    "busy count disagrees with held voices")

endmodule

// File: design/midi_voice_allocator.sv
// Top level of the MIDI voice allocator: controller plus datapath.
//
// Usage:
//   in_*  : one MIDI event per word; tuser carries the event kind (note on,
//           note off, other), tdata the channel, note and velocity.
//   out_* : voice commands; tuser is the action (start or stop), tdata the
//           voice, pitch, level and level-valid flag; tlast marks the final
//           command caused by an event.
//   cfg_* : one-bit write of poly_mode, taken any cycle; write it only idle.
// Timing: an event is taken in the idle state and decoded the next cycle.
//   A start passes the decode and start states before it lands in the output
//   register; the block is ready again once it is issued. A steal first issues
//   a stop from the steal state. A release walks every voice, one per cycle
//   unless the output stalls. Ignored events go back to idle after decode.
// The rate is set by the controller, which serves one event at a time and one
//   result per cycle, unless out_tready is low, through a single output register.
// Reset (rst_n low, synchronous) frees all voices and selects poly mode.
// A stalled receiver holds the output word; the block waits with the next
//   result and takes no new event until the current one is finished.
module midi_voice_allocator #(
  parameter int VOICES = mva_pkg::VOICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] channel, [10:4] note, [17:11] velocity, [23:18] zero
  input  logic [mva_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [mva_pkg::KIND_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] voice, [8:2] pitch, [13:9] level, [14] level_valid, [15] zero
  output logic [mva_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] action
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);
  import mva_pkg::*;

  mva_cmd_t cmd;
  mva_sts_t sts;

  mva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mva_dpath #(
    .VOICES (VOICES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
